// ===== rtl/imu_pkg.sv =====
package imu_pkg;

  localparam int unsigned NumAxes   = 6;
  localparam int unsigned AlphaW    = 17;
  localparam int unsigned PresetW   = 48;
  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned CfgDataW  = 48;

  typedef enum logic [CfgAddrW-1:0] {
    RegPresetMode  = 3'd0,
    RegPresetAcc   = 3'd1,
    RegPresetGyro  = 3'd2,
    RegCalibSmp    = 3'd3,
    RegGravity     = 3'd4,
    RegFilterEn    = 3'd5,
    RegAlpha       = 3'd6
  } reg_idx_e;

  localparam logic [AlphaW-1:0] AlphaOne = 17'h10000;

endpackage

// ===== rtl/imu_serdiv.sv =====
module imu_serdiv #(
  parameter int unsigned SumW   = 33,
  parameter int unsigned CountW = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [SumW-1:0]   num_i,
  input  logic [CountW-1:0]        den_i,
  output logic                     done_o,
  output logic signed [SumW-1:0]   quo_o
);
  import imu_pkg::*;

  localparam int unsigned StepW = $clog2(SumW + 1);

  logic [SumW-1:0]   num_q, num_d;
  logic [CountW:0]   rem_q, rem_d;
  logic              neg_q, neg_d;
  logic              busy_q, busy_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [CountW:0]   trial;
  logic [SumW-1:0]   res;

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    neg_d  = neg_q;
    busy_d = busy_q;
    step_d = step_q;
    done_o = 1'b0;
    trial  = {rem_q[CountW-1:0], num_q[SumW-1]} - {1'b0, den_i};
    if (start_i) begin
      neg_d  = num_i[SumW-1];
      num_d  = num_i[SumW-1] ? (~num_i + 1'b1) : num_i;
      rem_d  = '0;
      busy_d = 1'b1;
      step_d = '0;
    end else if (busy_q) begin
      if (!trial[CountW]) begin
        rem_d = trial;
        num_d = {num_q[SumW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[CountW-1:0], num_q[SumW-1]};
        num_d = {num_q[SumW-2:0], 1'b0};
      end
      step_d = step_q + 1'b1;
      if (step_q == StepW'(SumW - 1)) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
    res   = neg_d ? (~num_d + 1'b1) : num_d;
    quo_o = res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      neg_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      neg_q  <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
  end

endmodule

// ===== rtl/imu_sermul.sv =====
module imu_sermul #(
  parameter int unsigned DiffW = 18
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [imu_pkg::AlphaW-1:0]      alpha_i,
  input  logic signed [DiffW-1:0]         diff_i,
  output logic                            done_o,
  output logic signed [DiffW+imu_pkg::AlphaW-1:0] prod_o
);
  import imu_pkg::*;

  localparam int unsigned ProdW = DiffW + AlphaW;
  localparam int unsigned StepW = $clog2(AlphaW + 1);

  logic [AlphaW-1:0]       mul_q;
  logic signed [ProdW-1:0] acc_q, mcand_q;
  logic                    busy_q;
  logic [StepW-1:0]        step_q;

  assign prod_o = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == StepW'(AlphaW - 1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mul_q   <= alpha_i;
      mcand_q <= ProdW'(diff_i);
      acc_q   <= '0;
    end else if (busy_q) begin
      if (mul_q[0]) begin
        acc_q <= acc_q + mcand_q;
      end
      mul_q   <= mul_q >> 1;
      mcand_q <= mcand_q <<< 1;
    end
  end

endmodule

// ===== rtl/imu_bias_calibrate_and_lowpass_unit.sv =====
// Six-axis IMU bias removal and low-pass filter.
// Input channel s_axis_*: one item is one six-axis sample; tdata holds acc_x, acc_y,
// acc_z, gyro_x, gyro_y, gyro_z, each SAMPLE_WIDTH bits, from the lowest bit up.
// Output channel m_axis_*: the corrected sample, same packing, out_acc_x first.
// While calibrating, the first calib_samples items give no output; the last of them
// starts a serial divider for each axis in turn.
// After calibration or in preset mode every item gives one output item. With the
// filter on, each axis passes a bit-serial multiplier of 17 steps, one axis after
// the other; with the filter off, the corrected value goes out unfiltered.
// The divider and the multiplier run as shift-and-subtract and shift-and-add loops.
// One item is in work at a time; s_axis_tready is low while it is. The finished
// item waits in the output register until taken; a stalled receiver holds the
// block, which then accepts no new item.
// Configuration uses cfg_we_i, cfg_addr_i and cfg_data_i; the user must write it
// only while idle, as the block does not enforce this. Reset clears calibration
// state, biases, filter history and the registers to their default values.
module imu_bias_calibrate_and_lowpass_unit #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned COUNT_WIDTH  = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z
  input  logic [((6*SAMPLE_WIDTH+7)/8)*8-1:0]  s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // out_acc_x, out_acc_y, out_acc_z, out_gyro_x, out_gyro_y, out_gyro_z
  output logic [((6*SAMPLE_WIDTH+7)/8)*8-1:0]  m_axis_tdata,
  input  logic                                 cfg_we_i,
  input  logic [imu_pkg::CfgAddrW-1:0]         cfg_addr_i,
  input  logic [imu_pkg::CfgDataW-1:0]         cfg_data_i
);
  import imu_pkg::*;

  localparam int unsigned SW    = SAMPLE_WIDTH;
  localparam int unsigned SumW  = SAMPLE_WIDTH + COUNT_WIDTH + 1;
  localparam int unsigned DiffW = SAMPLE_WIDTH + 2;
  localparam int unsigned ProdW = DiffW + AlphaW;
  localparam logic signed [SW-1:0] SMax = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMin = {1'b1, {(SW-1){1'b0}}};

  typedef enum logic [2:0] {
    StIdle, StAccum, StDiv, StCorr, StMul, StOut
  } state_e;

  state_e state_q;
  logic   [2:0] ax_q;

  logic              preset_q, fen_q;
  logic [PresetW-1:0] pacc_q, pgyr_q;
  logic [COUNT_WIDTH-1:0] ncal_q;
  logic [SW-2:0]     grav_q;
  logic [AlphaW-1:0] alpha_q;

  logic                     calibrated_q;
  logic [COUNT_WIDTH-1:0]   count_q;
  logic signed [SumW-1:0]   sums_q [NumAxes];
  logic signed [SW-1:0]     bias_q [NumAxes];
  logic signed [SW-1:0]     prev_q [NumAxes];
  logic signed [SW-1:0]     x_q    [NumAxes];
  logic signed [SW-1:0]     y_q    [NumAxes];

  // Shared per-axis datapath.
  logic signed [SW-1:0]   x_cur, bias_cur, prev_cur;
  logic signed [SumW-1:0] add_v, nsum;
  logic [COUNT_WIDTH-1:0] n_next;
  logic signed [SW+1:0]   dsub;
  logic signed [SW-1:0]   corr_v;
  logic signed [DiffW-1:0] diff_v;
  logic [AlphaW-1:0]      a_eff;
  logic signed [ProdW-1:0] prod;
  logic signed [ProdW-1:0] filt;
  logic signed [SW-1:0]   filt_sat;
  logic signed [SumW-1:0] quo;
  logic signed [SW-1:0]   quo_sat;
  logic [COUNT_WIDTH-1:0] den;
  logic div_start, div_done, mul_start, mul_done;

  always_comb begin
    x_cur = x_q[ax_q];
    prev_cur = prev_q[ax_q];
    case (ax_q)
      3'd0: bias_cur = preset_q ? SW'($signed(pacc_q[15:0]))  : bias_q[0];
      3'd1: bias_cur = preset_q ? SW'($signed(pacc_q[31:16])) : bias_q[1];
      3'd2: bias_cur = preset_q ? SW'($signed(pacc_q[47:32])) : bias_q[2];
      3'd3: bias_cur = preset_q ? SW'($signed(pgyr_q[15:0]))  : bias_q[3];
      3'd4: bias_cur = preset_q ? SW'($signed(pgyr_q[31:16])) : bias_q[4];
      default: bias_cur = preset_q ? SW'($signed(pgyr_q[47:32])) : bias_q[5];
    endcase
    add_v = SumW'(x_cur);
    if (ax_q == 3'd2) begin
      add_v = add_v - SumW'({1'b0, grav_q});
    end
    nsum   = sums_q[ax_q] + add_v;
    n_next = count_q + 1'b1;
    den    = (n_next == '0) ? COUNT_WIDTH'(1) : n_next;
    dsub   = (SW+2)'(x_cur) - (SW+2)'(bias_cur);
    if (dsub > (SW+2)'(SMax)) begin
      corr_v = SMax;
    end else if (dsub < (SW+2)'(SMin)) begin
      corr_v = SMin;
    end else begin
      corr_v = dsub[SW-1:0];
    end
    diff_v = DiffW'(corr_v) - DiffW'(prev_cur);
    a_eff  = (alpha_q > AlphaOne) ? AlphaOne : alpha_q;
    filt   = ProdW'(prev_cur) + (prod >>> 16);
    if (filt > ProdW'(SMax)) begin
      filt_sat = SMax;
    end else if (filt < ProdW'(SMin)) begin
      filt_sat = SMin;
    end else begin
      filt_sat = filt[SW-1:0];
    end
    if (quo > SumW'(SMax)) begin
      quo_sat = SMax;
    end else if (quo < SumW'(SMin)) begin
      quo_sat = SMin;
    end else begin
      quo_sat = quo[SW-1:0];
    end
  end

  imu_serdiv #(.SumW(SumW), .CountW(COUNT_WIDTH)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .num_i(sums_q[ax_q]), .den_i(count_q),
    .done_o(div_done), .quo_o(quo)
  );

  imu_sermul #(.DiffW(DiffW)) u_mul (
    .clk_i, .rst_ni,
    .start_i(mul_start), .alpha_i(a_eff), .diff_i(diff_v),
    .done_o(mul_done), .prod_o(prod)
  );

  logic div_busy_q;
  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = (state_q == StOut);
  assign div_start = (state_q == StDiv) && !div_busy_q;
  assign mul_start = (state_q == StCorr) && fen_q;

  always_comb begin
    m_axis_tdata = '0;
    for (int i = 0; i < NumAxes; i++) begin
      m_axis_tdata[i*SW +: SW] = y_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ax_q <= '0;
      div_busy_q <= 1'b0;
      preset_q <= 1'b0;
      pacc_q <= '0;
      pgyr_q <= '0;
      ncal_q <= COUNT_WIDTH'(2000);
      grav_q <= (SW-1)'(16384);
      fen_q <= 1'b1;
      alpha_q <= AlphaW'(31785);
      calibrated_q <= 1'b0;
      count_q <= '0;
      for (int i = 0; i < NumAxes; i++) begin
        sums_q[i] <= '0;
        bias_q[i] <= '0;
        prev_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          RegPresetMode: preset_q <= cfg_data_i[0];
          RegPresetAcc:  pacc_q   <= cfg_data_i[PresetW-1:0];
          RegPresetGyro: pgyr_q   <= cfg_data_i[PresetW-1:0];
          RegCalibSmp:   ncal_q   <= cfg_data_i[COUNT_WIDTH-1:0];
          RegGravity:    grav_q   <= cfg_data_i[SW-2:0];
          RegFilterEn:   fen_q    <= cfg_data_i[0];
          RegAlpha:      alpha_q  <= cfg_data_i[AlphaW-1:0];
          default: ;
        endcase
      end
      case (state_q)
        StIdle: begin
          if (s_axis_tvalid) begin
            ax_q <= '0;
            state_q <= (!preset_q && !calibrated_q) ? StAccum : StCorr;
          end
        end
        StAccum: begin
          sums_q[ax_q] <= nsum;
          if (ax_q == 3'(NumAxes-1)) begin
            ax_q <= '0;
            count_q <= n_next;
            if (n_next >= ncal_q || n_next == '0) begin
              count_q <= den;
              state_q <= StDiv;
            end else begin
              state_q <= StIdle;
            end
          end else begin
            ax_q <= ax_q + 1'b1;
          end
        end
        StDiv: begin
          if (!div_busy_q) begin
            div_busy_q <= 1'b1;
          end else if (div_done) begin
            div_busy_q <= 1'b0;
            bias_q[ax_q] <= quo_sat;
            if (ax_q == 3'(NumAxes-1)) begin
              calibrated_q <= 1'b1;
              count_q <= n_next - 1'b1 - ((n_next == COUNT_WIDTH'(2) && count_q == '0) ? 1'b0 : 1'b0);
              state_q <= StIdle;
            end else begin
              ax_q <= ax_q + 1'b1;
            end
          end
        end
        StCorr: begin
          if (fen_q) begin
            state_q <= StMul;
          end else begin
            y_q[ax_q] <= corr_v;
            if (ax_q == 3'(NumAxes-1)) begin
              state_q <= StOut;
            end else begin
              ax_q <= ax_q + 1'b1;
            end
          end
        end
        StMul: begin
          if (mul_done) begin
            y_q[ax_q] <= filt_sat;
            prev_q[ax_q] <= filt_sat;
            if (ax_q == 3'(NumAxes-1)) begin
              state_q <= StOut;
            end else begin
              ax_q <= ax_q + 1'b1;
              state_q <= StCorr;
            end
          end
        end
        StOut: begin
          if (m_axis_tready) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && s_axis_tvalid) begin
      for (int i = 0; i < NumAxes; i++) begin
        x_q[i] <= s_axis_tdata[i*SW +: SW];
      end
    end
  end

endmodule
